FILE: rtl/core/tcce_pkg.sv
// Package with the constants, codes and state type of the text console engine.
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_WIDTH  = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_BLANK,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/text_console_char_engine.sv
// Top level of the text console engine: cell store, cursor, scroll and clear sequencer.
`timescale 1ns / 1ps
`default_nettype none
// The engine keeps an 80x25 store of 16-bit cells in one single-port-write memory and
// a line/column cursor, and handles one item at a time. After reset it sweeps the
// store to blanks with in_stall high; configuration writes are taken throughout. A put
// of a byte goes from the execute state to the done state, with the blanking or clear
// sweep between them for a scroll or form feed, and then to the output register. A read
// inside the screen passes a read-wait state between execute and done, and a read
// outside it goes straight to done. Scrolling does not move data: a top-row pointer
// advances and the freed row is blanked one cell per cycle. A form feed sweeps the
// whole store. The memory port takes one cell per cycle. A finished result waits in
// the output register while the next item is already taken and worked on.
module text_console_char_engine (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [tcce_pkg::ATTR_W-1:0] cfg_data,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        opcode,
	input  wire  [7:0]                 char_byte,
	input  wire  [tcce_pkg::ROW_W-1:0] read_line,
	input  wire  [tcce_pkg::COL_W-1:0] read_column,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [tcce_pkg::ROW_W-1:0] cursor_row,
	output logic [tcce_pkg::COL_W-1:0] cursor_col,
	output logic [tcce_pkg::CELL_W-1:0] cell_value
);
	import tcce_pkg::*;

	state_t state_q, state_d;

	logic [CELL_W-1:0] mem [0:CELL_COUNT-1];
	logic [CELL_W-1:0] rd_q;

	logic [ATTR_W-1:0] attr_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  cur_line_q;
	logic [COL_W-1:0]  cur_col_q;
	logic              op_q;
	logic [7:0]        byte_q;
	logic [ROW_W-1:0]  rline_q;
	logic [COL_W-1:0]  rcol_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              ff_q;
	logic [CELL_W-1:0] cell_q;
	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [CELL_W-1:0] out_cell_q;

	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [CELL_W-1:0] mem_wdata;
	logic              out_load;

	logic [ROW_W-1:0]  a_row;
	logic [COL_W-1:0]  a_col;
	logic [ROW_W:0]    prow_sum;
	logic [ROW_W-1:0]  prow;

	logic              printable;
	logic              read_in_range;
	logic [ROW_W:0]    t_line;
	logic [COL_W:0]    t_col;
	logic              need_scroll;
	logic [ROW_W-1:0]  n_line;
	logic [COL_W-1:0]  n_col;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign cell_value = out_cell_q;

	assign printable     = (byte_q >= CH_SPACE) && (byte_q <= CH_TILDE);
	assign read_in_range = (rline_q < ROW_W'(ROWS)) && (rcol_q < COL_W'(COLUMNS));

	always_comb begin
		t_line      = {1'b0, cur_line_q};
		t_col       = {1'b0, cur_col_q};
		need_scroll = 1'b0;
		if (printable) begin
			t_col = t_col + 1'b1;
		end else begin
			case (byte_q)
				CH_BS: begin
					if (cur_col_q != '0) begin
						t_col = t_col - 1'b1;
					end
				end
				CH_TAB: begin
					if (t_col >= (COL_W+1)'(COLUMNS - TAB_WIDTH)) begin
						t_line = t_line + 1'b1;
						t_col  = '0;
					end else begin
						t_col = (t_col & ~(COL_W+1)'(TAB_WIDTH - 1)) + (COL_W+1)'(TAB_WIDTH);
					end
				end
				CH_LF: begin
					t_line = t_line + 1'b1;
					t_col  = '0;
				end
				CH_CR: begin
					t_col = '0;
				end
				default: begin
				end
			endcase
		end
		if (t_col >= (COL_W+1)'(COLUMNS)) begin
			t_line = t_line + 1'b1;
			t_col  = '0;
		end
		if (t_line >= (ROW_W+1)'(ROWS)) begin
			need_scroll = 1'b1;
			t_line      = (ROW_W+1)'(ROWS - 1);
		end
		n_line = t_line[ROW_W-1:0];
		n_col  = t_col[COL_W-1:0];
	end

	always_comb begin
		if (op_q == OP_READ) begin
			a_row = rline_q;
			a_col = rcol_q;
		end else begin
			a_row = cur_line_q;
			a_col = cur_col_q;
		end
		prow_sum = {1'b0, a_row} + {1'b0, top_q};
		if (prow_sum >= (ROW_W+1)'(ROWS)) begin
			prow_sum = prow_sum - (ROW_W+1)'(ROWS);
		end
		prow = prow_sum[ROW_W-1:0];
		if (state_q == ST_BLANK) begin
			prow  = top_q;
			a_col = cnt_q[COL_W-1:0];
		end
		if (state_q == ST_CLEAR) begin
			mem_addr = cnt_q;
		end else begin
			mem_addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(a_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = BLANK_CELL;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ff_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (op_q == OP_READ) begin
					mem_re  = read_in_range;
					state_d = read_in_range ? ST_RDWAIT : ST_DONE;
				end else if (byte_q == CH_FF) begin
					state_d = ST_CLEAR;
				end else begin
					mem_we    = printable;
					mem_wdata = {attr_q, byte_q};
					state_d   = need_scroll ? ST_BLANK : ST_DONE;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_DONE;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			top_q       <= '0;
			cur_line_q  <= '0;
			cur_col_q   <= '0;
			cnt_q       <= '0;
			ff_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						cnt_q      <= '0;
						top_q      <= '0;
						cur_line_q <= '0;
						cur_col_q  <= '0;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					ff_q  <= (op_q == OP_PUT) && (byte_q == CH_FF);
					if (op_q == OP_PUT) begin
						cur_line_q <= n_line;
						cur_col_q  <= n_col;
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
						cnt_q <= '0;
						top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q    <= opcode;
			byte_q  <= char_byte;
			rline_q <= read_line;
			rcol_q  <= read_column;
		end
		if (state_q == ST_EXEC) begin
			cell_q <= '0;
		end
		if (state_q == ST_RDWAIT) begin
			cell_q <= rd_q;
		end
		if (out_load) begin
			out_row_q  <= cur_line_q;
			out_col_q  <= cur_col_q;
			out_cell_q <= cell_q;
		end
	end

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_line_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLUMNS)))
		else $error("cursor left the screen");

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_q < ROW_W'(ROWS))
		else $error("top row pointer out of range");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || mem_re) |-> (mem_addr < ADDR_W'(CELL_COUNT)))
		else $error("cell store address out of range");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!mem_we && !mem_re))
		else $error("cell store accessed while idle");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && (cursor_row < ROW_W'(ROWS))))
		else $error("result beat lost or cursor row out of range");

endmodule
`default_nettype wire
